/* sv/udwc_pkg.sv */
// Package for the UTF-8 display width counter.
// Holds shared types, widths and the code point width classification.
// No dependencies.
package udwc_pkg;

  localparam int SUM_BITS = 16;
  localparam int OUT_BITS = 16;
  localparam int CP_BITS = 21;
  localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

  typedef logic [1:0] width_t;

  typedef struct packed {
    logic             done;
    logic [CP_BITS-1:0] cp;
    logic             bad;
    logic             last;
  } item_t;

  function automatic logic in_zero(input logic [CP_BITS-1:0] c);
    return (c inside {[21'h0000:21'h001F], [21'h007F:21'h00A0], [21'h0300:21'h036F],
      [21'h0483:21'h0486], [21'h0488:21'h0489], [21'h0591:21'h05BD], 21'h05BF,
      [21'h05C1:21'h05C2], [21'h05C4:21'h05C5], 21'h05C7, [21'h0600:21'h0603],
      [21'h0610:21'h0615], [21'h064B:21'h065E], 21'h0670, [21'h06D6:21'h06E4],
      [21'h06E7:21'h06E8], [21'h06EA:21'h06ED], 21'h070F, 21'h0711,
      [21'h0730:21'h074A], [21'h07A6:21'h07B0], [21'h07EB:21'h07F3],
      [21'h0901:21'h0902], 21'h093C, [21'h0941:21'h0948], 21'h094D,
      [21'h0951:21'h0954], [21'h0962:21'h0963], 21'h0981, 21'h09BC,
      [21'h09C1:21'h09C4], 21'h09CD, [21'h09E2:21'h09E3], [21'h0A01:21'h0A02],
      21'h0A3C, [21'h0A41:21'h0A42], [21'h0A47:21'h0A48], [21'h0A4B:21'h0A4D],
      [21'h0A70:21'h0A71], [21'h0A81:21'h0A82], 21'h0ABC, [21'h0AC1:21'h0AC5],
      [21'h0AC7:21'h0AC8], 21'h0ACD, [21'h0AE2:21'h0AE3], 21'h0B01, 21'h0B3C,
      21'h0B3F, [21'h0B41:21'h0B43], 21'h0B4D, 21'h0B56, 21'h0B82, 21'h0BC0,
      21'h0BCD, [21'h0C3E:21'h0C40], [21'h0C46:21'h0C48], [21'h0C4A:21'h0C4D],
      [21'h0C55:21'h0C56], 21'h0CBC, 21'h0CBF, 21'h0CC6, [21'h0CCC:21'h0CCD],
      [21'h0CE2:21'h0CE3], [21'h0D41:21'h0D43], 21'h0D4D, 21'h0DCA,
      [21'h0DD2:21'h0DD4], 21'h0DD6, 21'h0E31, [21'h0E34:21'h0E3A],
      [21'h0E47:21'h0E4E], 21'h0EB1, [21'h0EB4:21'h0EB9], [21'h0EBB:21'h0EBC],
      [21'h0EC8:21'h0ECD], [21'h0F18:21'h0F19], 21'h0F35, 21'h0F37, 21'h0F39,
      [21'h0F71:21'h0F7E], [21'h0F80:21'h0F84], [21'h0F86:21'h0F87],
      [21'h0F90:21'h0F97], [21'h0F99:21'h0FBC], 21'h0FC6, [21'h102D:21'h1030],
      21'h1032, [21'h1036:21'h1037], 21'h1039, [21'h1058:21'h1059],
      [21'h1160:21'h11FF], 21'h135F, [21'h1712:21'h1714], [21'h1732:21'h1734],
      [21'h1752:21'h1753], [21'h1772:21'h1773], [21'h17B4:21'h17B5],
      [21'h17B7:21'h17BD], 21'h17C6, [21'h17C9:21'h17D3], 21'h17DD,
      [21'h180B:21'h180D], 21'h18A9, [21'h1920:21'h1922], [21'h1927:21'h1928],
      21'h1932, [21'h1939:21'h193B], [21'h1A17:21'h1A18], [21'h1B00:21'h1B03],
      21'h1B34, [21'h1B36:21'h1B3A], 21'h1B3C, 21'h1B42, [21'h1B6B:21'h1B73],
      [21'h1DC0:21'h1DCA], [21'h1DFE:21'h1DFF], [21'h200B:21'h200F],
      [21'h202A:21'h202E], [21'h2060:21'h2063], [21'h206A:21'h206F],
      [21'h20D0:21'h20EF], [21'h302A:21'h302F], [21'h3099:21'h309A], 21'hA806,
      21'hA80B, [21'hA825:21'hA826], 21'hFB1E, [21'hFE00:21'hFE0F],
      [21'hFE20:21'hFE23], 21'hFEFF, [21'hFFF9:21'hFFFB], [21'h10A01:21'h10A03],
      [21'h10A05:21'h10A06], [21'h10A0C:21'h10A0F], [21'h10A38:21'h10A3A],
      21'h10A3F, [21'h1D167:21'h1D169], [21'h1D173:21'h1D182],
      [21'h1D185:21'h1D18B], [21'h1D1AA:21'h1D1AD], [21'h1D242:21'h1D244],
      21'hE0001, [21'hE0020:21'hE007F], [21'hE0100:21'hE01EF]});
  endfunction

  function automatic logic in_wide(input logic [CP_BITS-1:0] c);
    return (c inside {[21'h1100:21'h115F], [21'h2329:21'h232A], [21'h2E80:21'h303E],
      [21'h3040:21'hA4CF], [21'hAC00:21'hD7A3], [21'hF900:21'hFAFF],
      [21'hFE10:21'hFE19], [21'hFE30:21'hFE6F], [21'hFF00:21'hFF60],
      [21'hFFE0:21'hFFE6], [21'h1F000:21'h1F644], [21'h20000:21'h2FFFD],
      [21'h30000:21'h3FFFD]});
  endfunction

  function automatic width_t cp_width(input logic [CP_BITS-1:0] c);
    if (in_zero(c)) return 2'd0;
    if (in_wide(c)) return 2'd2;
    return 2'd1;
  endfunction

endpackage

/* sv/udwc_decode.sv */
// Front end: accepts bytes and assembles UTF-8 code points.
// Depends on udwc_pkg.
module udwc_decode import udwc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  text_byte,
  input  logic        end_of_string,
  input  logic        take,
  output item_t       item
);

  logic [CP_BITS-1:0] part, part_next;
  logic [1:0]         left, left_next;

  always_comb begin
    logic handled;
    handled = 1'b0;
    part_next = part;
    left_next = left;
    item = '0;
    item.last = end_of_string;
    if (left != 2'd0) begin
      if (text_byte[7:6] == 2'b10) begin
        part_next = {part[CP_BITS-7:0], text_byte[5:0]};
        left_next = left - 2'd1;
        if (left == 2'd1) begin
          item.done = 1'b1;
          item.cp = part_next;
        end
        handled = 1'b1;
      end else begin
        item.bad = 1'b1;
        left_next = 2'd0;
        part_next = '0;
      end
    end
    if (!handled) begin
      if (text_byte < 8'h80) begin
        item.done = 1'b1;
        item.cp = CP_BITS'(text_byte);
      end else if (text_byte >= 8'hF0) begin
        part_next = CP_BITS'(text_byte[2:0]);
        left_next = 2'd3;
      end else if (text_byte >= 8'hE0) begin
        part_next = CP_BITS'(text_byte[3:0]);
        left_next = 2'd2;
      end else if (text_byte >= 8'hC0) begin
        part_next = CP_BITS'(text_byte[4:0]);
        left_next = 2'd1;
      end else begin
        item.bad = 1'b1;
      end
    end
    if (end_of_string) begin
      if (left_next != 2'd0) item.bad = 1'b1;
      left_next = 2'd0;
      part_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      part <= '0;
      left <= '0;
    end else if (take) begin
      part <= part_next;
      left <= left_next;
    end
  end

endmodule

/* sv/udwc_fifo.sv */
// Two-entry queue between decode and accumulate.
// Depends on udwc_pkg.
module udwc_fifo import udwc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  item_t wdata,
  output logic  full,
  input  logic  rd,
  output item_t rdata,
  output logic  empty
);

  item_t      mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign full = cnt == 2'd2;
  assign empty = cnt == 2'd0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= '0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
  end

endmodule

/* sv/udwc_accum.sv */
// Back end: classifies code point width, sums, and emits per-string results.
// Depends on udwc_pkg.
module udwc_accum import udwc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  item_t               item,
  input  logic                item_valid,
  output logic                item_take,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OUT_BITS-1:0] total_columns,
  output logic                bad_sequence
);

  logic [SUM_BITS-1:0] sum, sum_next;
  logic                err, err_next;
  logic [SUM_BITS:0]   wide;

  assign item_take = item_valid && (!out_valid || out_ready);
  assign wide = {1'b0, sum} + (SUM_BITS+1)'(item.done ? cp_width(item.cp) : 2'd0);

  always_comb begin
    sum_next = wide[SUM_BITS] ? SUM_MAX : wide[SUM_BITS-1:0];
    err_next = err | item.bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      err <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (item_take) begin
        if (item.last) begin
          sum <= '0;
          err <= 1'b0;
          out_valid <= 1'b1;
        end else begin
          sum <= sum_next;
          err <= err_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && item.last) begin
      if (SUM_BITS > OUT_BITS && sum_next > SUM_BITS'({OUT_BITS{1'b1}}))
        total_columns <= {OUT_BITS{1'b1}};
      else
        total_columns <= OUT_BITS'(sum_next);
      bad_sequence <= err_next;
    end
  end

endmodule

/* sv/utf8_display_width_counter.sv */
// UTF-8 display width counter: takes bytes, with end_of_string on the final
// byte, and returns the saturating column count and a sticky bad-sequence
// flag. Sustains one byte per cycle unless out_ready stalls; a decoder feeds
// a two-entry queue that the width/sum stage drains into an output register.
// Depends on udwc_pkg, udwc_decode, udwc_fifo, udwc_accum.
module utf8_display_width_counter import udwc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          text_byte,
  input  logic                end_of_string,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OUT_BITS-1:0] total_columns,
  output logic                bad_sequence
);

  item_t dec_item, q_item;
  logic  full, empty, take, q_take;

  assign in_ready = !full;
  assign take = in_valid && in_ready;

  udwc_decode u_dec (
    .clk, .rst, .text_byte, .end_of_string, .take, .item(dec_item)
  );

  udwc_fifo u_q (
    .clk, .rst, .wr(take), .wdata(dec_item), .full,
    .rd(q_take), .rdata(q_item), .empty
  );

  udwc_accum u_acc (
    .clk, .rst, .item(q_item), .item_valid(!empty), .item_take(q_take),
    .out_valid, .out_ready, .total_columns, .bad_sequence
  );

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_noovf: assert property (@(posedge clk) disable iff (rst)
    full |-> !take) else $error("queue overflow");
  a_nounder: assert property (@(posedge clk) disable iff (rst)
    q_take |-> !empty) else $error("queue underflow");
`endif

endmodule
